@@ hdl/src_pkg.sv @@
package src_pkg;

  localparam int NUM_AXES = 3;
  localparam int AXIS_W   = 2;
  localparam int REG_W    = 24;
  localparam int CMD_W    = 16;
  localparam int RATE_W   = 23;

  localparam logic [REG_W-1:0] RATES_RESET = 24'h460064;

  // variable divider: quotient bits and divisor width
  localparam int QW       = 23;
  localparam int DN_W     = 22;
  localparam int DIV_SPS  = 4;
  localparam int DIV_STG  = (QW + DIV_SPS - 1) / DIV_SPS;

  // divide by 25 of the rounded command product, reciprocal multiply
  // dividend stays below 2^39, split into three 13-bit digits
  localparam int CD_XW    = 39;
  localparam int CD_DW    = 13;
  localparam int CD_MW    = 40;
  localparam int CD_PW    = CD_DW + CD_MW;
  localparam int CD_SW    = CD_PW + CD_DW + 1;
  localparam int CD_FW    = CD_XW + CD_MW + 1;
  localparam int CD_QW    = 35;
  localparam int CD_SH    = 44;
  localparam logic [CD_MW-1:0] CD_RECIP = 40'd703687441777;

  localparam logic [DN_W-1:0]   UNIT_DEN = 22'd3276800;
  localparam logic [DN_W-1:0]   DN_MIN   = 22'd32768;
  localparam logic [RATE_W-1:0] RATE_MAX = 23'h3fffff;
  localparam logic [RATE_W-1:0] RATE_MIN = 23'h400000;

  typedef struct packed {
    logic neg;
    logic bad;
    logic ovf;
  } src_side_t;

endpackage

@@ hdl/stick_rate_curve.sv @@
// throughput: one item per cycle; the pipeline only holds when the output
// register and its skid stage are both full
// the divide-by-25 is a pipelined reciprocal multiply, the rate divider is the long section
// reset: all valid bits and the skid stage clear, rate registers load 0x460064
module stick_rate_curve (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // stick_command [15:0], stick_magnitude [31:16]
  input  logic [1:0]  s_axis_tuser,   // axis_select [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // angle_rate [22:0], zero [23]
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i
);
  import src_pkg::*;

  logic [REG_W-1:0] rates_q [NUM_AXES];
  logic             en;
  logic             svalid_q, ovalid_q;
  logic [RATE_W-1:0] sdata_q, odata_q;

  assign en            = !svalid_q;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) rates_q[i] <= RATES_RESET;
    end else if (cfg_we_i) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        if (cfg_idx_i == AXIS_W'(i)) rates_q[i] <= cfg_data_i;
      end
    end
  end

  // stage 1: capture and pick axis settings
  logic             bad_in;
  logic [REG_W-1:0] sel;
  always_comb begin
    bad_in = (32'(s_axis_tuser) >= NUM_AXES);
    sel    = rates_q[0];
    for (int i = 0; i < NUM_AXES; i++) begin
      if (s_axis_tuser == AXIS_W'(i)) sel = rates_q[i];
    end
  end

  logic              v1_q, bad1_q;
  logic signed [15:0] c1_q;
  logic [15:0]       m1_q;
  logic [7:0]        rc1_q, ex1_q, su1_q;

  // stage 2: m^2, rate scale, super denominator
  logic              v2_q, bad2_q;
  logic signed [15:0] c2_q;
  logic [15:0]       m2_q;
  logic [7:0]        ex2_q;
  logic [31:0]       mm2_q;
  logic [16:0]       r2_q, r_d;
  logic [DN_W-1:0]   dn2_q, dn_d;
  logic [23:0]       msu;
  logic signed [25:0] dsig;

  always_comb begin
    r_d = 17'(rc1_q) * 17'd100;
    if (rc1_q > 8'd200) r_d = r_d + 17'd1454 * 17'(rc1_q - 8'd200);
    msu  = 24'(m1_q) * 24'(su1_q);
    dsig = $signed({4'b0, UNIT_DEN}) - $signed({2'b0, msu});
    if (dsig < $signed({4'b0, DN_MIN})) dn_d = DN_MIN;
    else dn_d = dsig[DN_W-1:0];
  end

  // stage 3: m^3
  logic              v3_q, bad3_q;
  logic signed [15:0] c3_q;
  logic [7:0]        ex3_q;
  logic [16:0]       r3_q;
  logic [DN_W-1:0]   dn3_q;
  logic [47:0]       cube3_q;

  // stage 4: expo blend factor
  logic              v4_q, bad4_q;
  logic signed [15:0] c4_q;
  logic [16:0]       r4_q;
  logic [DN_W-1:0]   dn4_q;
  logic signed [42:0] f4_q, f_d;
  logic [48:0]       csum;
  logic signed [8:0] wgt;

  always_comb begin
    csum = {1'b0, cube3_q} + 49'd16384;
    wgt  = 9'sd100 - $signed({1'b0, ex3_q});
    f_d  = $signed({9'b0, csum[48:15]}) * $signed({35'b0, ex3_q})
         + ($signed({{34{wgt[8]}}, wgt}) <<< 30);
  end

  // stage 5: command times blend
  logic              v5_q, bad5_q;
  logic [16:0]       r5_q;
  logic [DN_W-1:0]   dn5_q;
  logic signed [58:0] p5_q;

  // stage 6: magnitude, rounding offset, drop the power of two in the scale
  logic              v6_q, bad6_q, neg6_q;
  logic [16:0]       r6_q;
  logic [DN_W-1:0]   dn6_q;
  logic [CD_XW-1:0]  b6_q;
  logic [58:0]       pmag, pround;

  always_comb begin
    pmag   = p5_q[58] ? 59'(-p5_q) : 59'(p5_q);
    pround = pmag + 59'd1638400;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bad1_q  <= bad_in;
      c1_q    <= $signed(s_axis_tdata[15:0]);
      m1_q    <= s_axis_tdata[31:16];
      rc1_q   <= sel[7:0];
      ex1_q   <= sel[15:8];
      su1_q   <= sel[23:16];

      bad2_q  <= bad1_q;
      c2_q    <= c1_q;
      m2_q    <= m1_q;
      ex2_q   <= ex1_q;
      mm2_q   <= 32'(m1_q) * 32'(m1_q);
      r2_q    <= r_d;
      dn2_q   <= dn_d;

      bad3_q  <= bad2_q;
      c3_q    <= c2_q;
      ex3_q   <= ex2_q;
      r3_q    <= r2_q;
      dn3_q   <= dn2_q;
      cube3_q <= 48'(mm2_q) * 48'(m2_q);

      bad4_q  <= bad3_q;
      c4_q    <= c3_q;
      r4_q    <= r3_q;
      dn4_q   <= dn3_q;
      f4_q    <= f_d;

      bad5_q  <= bad4_q;
      r5_q    <= r4_q;
      dn5_q   <= dn4_q;
      p5_q    <= $signed({{43{c4_q[15]}}, c4_q}) * $signed({{16{f4_q[42]}}, f4_q});

      bad6_q  <= bad5_q;
      neg6_q  <= p5_q[58];
      r6_q    <= r5_q;
      dn6_q   <= dn5_q;
      b6_q    <= pround[CD_XW+16:17];
    end
  end

  // stage 7: partial products of the multiply by the reciprocal of 25
  logic              v7_q, bad7_q, neg7_q;
  logic [16:0]       r7_q;
  logic [DN_W-1:0]   dn7_q;
  logic [CD_PW-1:0]  pl7_q, pm7_q, ph7_q;

  // stage 8: fold the upper two partial products
  logic              v8_q, bad8_q, neg8_q;
  logic [16:0]       r8_q;
  logic [DN_W-1:0]   dn8_q;
  logic [CD_PW-1:0]  pl8_q;
  logic [CD_SW-1:0]  ps8_q;

  // stage 9: full product, quotient from its upper bits
  logic              v9_q, bad9_q, neg9_q;
  logic [16:0]       r9_q;
  logic [DN_W-1:0]   dn9_q;
  logic [CD_QW-1:0]  q9_q;
  logic [CD_FW-1:0]  prod;

  assign prod = CD_FW'(pl8_q) + (CD_FW'(ps8_q) << CD_DW);

  // stage 10: rate scale times command
  logic              v10_q, bad10_q, neg10_q;
  logic [DN_W-1:0]   dn10_q;
  logic [54:0]       n10_q;

  // stage 11: fold the 1024 and the rounding half into the dividend
  logic              v11_q;
  src_side_t         side11_q;
  logic [DN_W-1:0]   dn11_q;
  logic [45:0]       a11_q;
  logic [55:0]       nsum;

  assign nsum = {1'b0, n10_q} + (56'(dn10_q) << 9);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
      v11_q <= 1'b0;
    end else if (en) begin
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      v9_q  <= v8_q;
      v10_q <= v9_q;
      v11_q <= v10_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bad7_q       <= bad6_q;
      neg7_q       <= neg6_q;
      r7_q         <= r6_q;
      dn7_q        <= dn6_q;
      pl7_q        <= CD_PW'(b6_q[CD_DW-1:0]) * CD_PW'(CD_RECIP);
      pm7_q        <= CD_PW'(b6_q[2*CD_DW-1:CD_DW]) * CD_PW'(CD_RECIP);
      ph7_q        <= CD_PW'(b6_q[3*CD_DW-1:2*CD_DW]) * CD_PW'(CD_RECIP);

      bad8_q       <= bad7_q;
      neg8_q       <= neg7_q;
      r8_q         <= r7_q;
      dn8_q        <= dn7_q;
      pl8_q        <= pl7_q;
      ps8_q        <= CD_SW'(pm7_q) + (CD_SW'(ph7_q) << CD_DW);

      bad9_q       <= bad8_q;
      neg9_q       <= neg8_q;
      r9_q         <= r8_q;
      dn9_q        <= dn8_q;
      q9_q         <= prod[CD_SH+CD_QW-1:CD_SH];

      bad10_q      <= bad9_q;
      neg10_q      <= neg9_q;
      dn10_q       <= dn9_q;
      n10_q        <= 55'(r9_q) * 55'(q9_q);

      side11_q.neg <= neg10_q;
      side11_q.bad <= bad10_q;
      side11_q.ovf <= (nsum[55:33] >= {1'b0, dn10_q});
      dn11_q       <= dn10_q;
      a11_q        <= nsum[55:10];
    end
  end

  logic              dv;
  src_side_t         dside;
  logic [QW-1:0]     dq;

  src_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v11_q),
    .side_i  (side11_q),
    .num_i   (a11_q[QW-1:0]),
    .rem_i   (a11_q[QW+DN_W-1:QW]),
    .den_i   (dn11_q),
    .valid_o (dv),
    .side_o  (dside),
    .quo_o   (dq)
  );

  // sign and saturation, zero for a bad axis select
  logic [RATE_W-1:0] res;
  always_comb begin
    if (dside.bad) begin
      res = '0;
    end else if (dside.neg) begin
      if (dside.ovf || dq > RATE_MIN) res = RATE_MIN;
      else res = RATE_W'(-dq);
    end else begin
      if (dside.ovf || dq[QW-1]) res = RATE_MAX;
      else res = dq;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      svalid_q <= 1'b0;
    end else if (svalid_q) begin
      if (m_axis_tready) svalid_q <= 1'b0;
    end else if (!ovalid_q || m_axis_tready) begin
      ovalid_q <= dv;
    end else if (dv) begin
      svalid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (svalid_q) begin
      if (m_axis_tready) odata_q <= sdata_q;
    end else if (!ovalid_q || m_axis_tready) begin
      odata_q <= res;
    end else begin
      sdata_q <= res;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {1'b0, odata_q};

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    svalid_q |-> ovalid_q) else $error("skid holds an item while output is empty");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !m_axis_tready && !svalid_q && dv) |=> svalid_q)
    else $error("item from pipeline not parked in skid");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (svalid_q && m_axis_tready) |=> (!svalid_q && ovalid_q))
    else $error("skid item not moved to output");

endmodule

@@ hdl/src_div.sv @@
module src_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  src_pkg::src_side_t       side_i,
  input  logic [src_pkg::QW-1:0]   num_i,
  input  logic [src_pkg::DN_W-1:0] rem_i,
  input  logic [src_pkg::DN_W-1:0] den_i,
  output logic                     valid_o,
  output src_pkg::src_side_t       side_o,
  output logic [src_pkg::QW-1:0]   quo_o
);
  import src_pkg::*;

  logic            v_q   [DIV_STG];
  src_side_t       side_q[DIV_STG];
  logic [DN_W-1:0] rem_q [DIV_STG];
  logic [QW-1:0]   w_q   [DIV_STG];
  logic [DN_W-1:0] den_q [DIV_STG];

  for (genvar k = 0; k < DIV_STG; k++) begin : g_stg
    logic            v_in;
    src_side_t       side_in;
    logic [DN_W-1:0] rem_in, den_in, rem_d;
    logic [QW-1:0]   w_in, w_d;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign side_in = side_i;
      assign rem_in  = rem_i;
      assign w_in    = num_i;
      assign den_in  = den_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign side_in = side_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign w_in    = w_q[k-1];
      assign den_in  = den_q[k-1];
    end

    // restoring steps, quotient bits shift in as dividend bits shift out
    always_comb begin
      logic [DN_W:0] t;
      rem_d = rem_in;
      w_d   = w_in;
      for (int j = 0; j < DIV_SPS; j++) begin
        if (k * DIV_SPS + j < QW) begin
          t   = {rem_d, w_d[QW-1]};
          w_d = {w_d[QW-2:0], 1'b0};
          if (t >= {1'b0, den_in}) begin
            t      = t - {1'b0, den_in};
            w_d[0] = 1'b1;
          end
          rem_d = t[DN_W-1:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
        rem_q[k]  <= rem_d;
        w_q[k]    <= w_d;
        den_q[k]  <= den_in;
      end
    end
  end

  assign valid_o = v_q[DIV_STG-1];
  assign side_o  = side_q[DIV_STG-1];
  assign quo_o   = w_q[DIV_STG-1];

endmodule
